// ===== rtl/core/assert_macros.svh =====
// Concurrent check helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define AGSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, muted during reset.
`define AGSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== rtl/core/agsr_pkg.sv =====
package agsr_pkg;

  localparam int unsigned SecW    = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned SbW     = 14;
  localparam int unsigned OffW    = 47;
  localparam int unsigned LenW    = 45;
  localparam int unsigned NumCell = 32;
  localparam int unsigned IdxW    = 3;

  localparam logic [SbW-1:0] SectorBytesReset = 14'd512;

  // Register index codes.
  typedef enum logic [IdxW-1:0] {
    REG_GROUP_SIZE       = 3'd0,
    REG_GROUP_ALTERNATES = 3'd1,
    REG_ALTERNATE_OFFSET = 3'd2,
    REG_FRONT_PORCH      = 3'd3,
    REG_SECTOR_BYTES     = 3'd4,
    REG_PARTITION_BASE   = 3'd5
  } agsr_reg_t;

  // Settings as seen by the datapath, with derived grouping terms.
  typedef struct packed {
    logic [HalfW-1:0] group_size;
    logic [HalfW-1:0] group_alternates;
    logic [HalfW-1:0] alternate_offset;
    logic [HalfW-1:0] front_porch;
    logic [SbW-1:0]   sector_bytes;
    logic [HalfW-1:0] usable;
    logic             grouped;
  } agsr_cfg_t;

  // Division cell payload: num shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [SecW-1:0]  cnt;
    logic [SecW-1:0]  num;
    logic [HalfW-1:0] rem;
  } agsr_div_t;

endpackage

// ===== rtl/core/alt_group_sector_remap.sv =====
// Channel   | valid      | stall      | payload
// ----------+------------+------------+--------------------------------------
// request   | in_valid   | in_stall   | rel_sector[31:0], remaining[31:0]
// result    | out_valid  | out_stall  | byte_offset[46:0], byte_length[44:0],
//           |            |            | run_sectors[31:0]
// settings  | wr_en      | (none)     | wr_index[2:0], wr_data[31:0]
//
// Throughput is one request per cycle while out_stall stays low. From acceptance
// to out_valid a request passes one input stage, 32 division cells, four mapping stages.
// Latency is set by the 32-cell chain that yields one quotient bit per cell.
// Reset (rst, synchronous) empties every stage; settings return to zero and
// sector_bytes to 512. Derived grouping terms are registered from the settings.
// A stall on the result side holds only full stages; empty stages keep
// filling, so requests are taken until every stage holds a request.

`include "assert_macros.svh"

module alt_group_sector_remap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] rel_sector,
  input  logic [31:0] remaining,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [46:0] byte_offset,
  output logic [44:0] byte_length,
  output logic [31:0] run_sectors,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  // Settings registers.
  logic [15:0] group_size;
  logic [15:0] group_alternates;
  logic [15:0] alternate_offset;
  logic [15:0] front_porch;
  logic [13:0] sector_bytes;
  logic [31:0] partition_base;
  // Derived grouping terms, registered to keep them off the cell path.
  logic [15:0] usable;
  logic        grouped;

  agsr_pkg::agsr_cfg_t cfg;

  // Stage 0 is the input register; stage k+1 is held by cell k.
  logic                 stage_valid [0:agsr_pkg::NumCell];
  agsr_pkg::agsr_div_t  stage_data  [0:agsr_pkg::NumCell];
  logic                 stage_ready [1:agsr_pkg::NumCell];
  logic                 map_ready;
  logic                 st0_load;
  logic [31:0]          sec_c;

  // Settings writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size       <= '0;
      group_alternates <= '0;
      alternate_offset <= '0;
      front_porch      <= '0;
      sector_bytes     <= agsr_pkg::SectorBytesReset;
      partition_base   <= '0;
    end else if (wr_en) begin
      case (agsr_pkg::agsr_reg_t'(wr_index))
        agsr_pkg::REG_GROUP_SIZE:       group_size       <= wr_data[15:0];
        agsr_pkg::REG_GROUP_ALTERNATES: group_alternates <= wr_data[15:0];
        agsr_pkg::REG_ALTERNATE_OFFSET: alternate_offset <= wr_data[15:0];
        agsr_pkg::REG_FRONT_PORCH:      front_porch      <= wr_data[15:0];
        agsr_pkg::REG_SECTOR_BYTES:     sector_bytes     <= wr_data[13:0];
        agsr_pkg::REG_PARTITION_BASE:   partition_base   <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable  <= '0;
      grouped <= 1'b0;
    end else begin
      usable  <= group_size - group_alternates;
      grouped <= (group_alternates < group_size);
    end
  end

  always_comb begin
    cfg.group_size       = group_size;
    cfg.group_alternates = group_alternates;
    cfg.alternate_offset = alternate_offset;
    cfg.front_porch      = front_porch;
    cfg.sector_bytes     = sector_bytes;
    cfg.usable           = usable;
    cfg.grouped          = grouped;
  end

  // Input stage: add the partition base with 32-bit wrap and seed the divider.
  assign sec_c    = rel_sector + partition_base;
  assign st0_load = !stage_valid[0] || stage_ready[1];
  assign in_stall = !st0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (st0_load) begin
      stage_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st0_load) begin
      stage_data[0].sec <= sec_c;
      stage_data[0].cnt <= remaining;
      stage_data[0].num <= sec_c;
      stage_data[0].rem <= '0;
    end
  end

  // Division chain: each cell retires one quotient bit, MSB first.
  for (genvar k = 0; k < agsr_pkg::NumCell; k++) begin : g_cell
    logic down_ready;
    if (k == agsr_pkg::NumCell - 1) begin : g_last
      assign down_ready = map_ready;
    end else begin : g_mid
      assign down_ready = stage_ready[k+2];
    end

    agsr_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .divisor    (usable),
      .up_valid   (stage_valid[k]),
      .up_data    (stage_data[k]),
      .up_ready   (stage_ready[k+1]),
      .down_ready (down_ready),
      .valid      (stage_valid[k+1]),
      .data       (stage_data[k+1])
    );
  end

  // Band skip, run clip and byte scaling.
  agsr_map u_map (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (stage_valid[agsr_pkg::NumCell]),
    .up_data     (stage_data[agsr_pkg::NumCell]),
    .up_ready    (map_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_offset (byte_offset),
    .byte_length (byte_length),
    .run_sectors (run_sectors)
  );

  `AGSR_ASSERT_NOW(a_stall_only_full, clk, rst, in_stall, stage_valid[0])
  `AGSR_ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && !in_stall, stage_valid[0])
  `AGSR_ASSERT_NOW(a_rem_below_div, clk, rst, stage_valid[agsr_pkg::NumCell] && grouped, stage_data[agsr_pkg::NumCell].rem < usable)

endmodule

// ===== rtl/core/agsr_div_cell.sv =====
module agsr_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [15:0]             divisor,
  input  logic                    up_valid,
  input  agsr_pkg::agsr_div_t     up_data,
  output logic                    up_ready,
  input  logic                    down_ready,
  output logic                    valid,
  output agsr_pkg::agsr_div_t     data
);

  logic [16:0]         trial;
  logic                fits;
  agsr_pkg::agsr_div_t data_next;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {up_data.rem, up_data.num[agsr_pkg::SecW-1]};
    fits      = (trial >= {1'b0, divisor});
    data_next = up_data;
    data_next.num = {up_data.num[agsr_pkg::SecW-2:0], fits};
    if (fits) begin
      data_next.rem = 16'(trial - {1'b0, divisor});
    end else begin
      data_next.rem = trial[15:0];
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/core/agsr_map.sv =====
`include "assert_macros.svh"

module agsr_map (
  input  logic                  clk,
  input  logic                  rst,
  input  agsr_pkg::agsr_cfg_t   cfg,
  input  logic                  up_valid,
  input  agsr_pkg::agsr_div_t   up_data,
  output logic                  up_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [46:0]           byte_offset,
  output logic [44:0]           byte_length,
  output logic [31:0]           run_sectors
);

  logic        v1, v2, v3, v4;
  logic        ld1, ld2, ld3, ld4;

  // stage 1
  logic [16:0] within_c, limit_c;
  logic [31:0] run_c;
  logic [47:0] qgs_c;
  logic [16:0] within1;
  logic [31:0] run1, sec1;
  logic [47:0] qgs1;
  logic        grp1;
  // stage 2
  logic [47:0] phys_c;
  logic [46:0] phys2;
  logic [31:0] run2;
  // stage 3
  logic [37:0] plo3;
  logic [22:0] phi3;
  logic [44:0] len3;
  logic [31:0] run3;

  assign ld4 = !v4 || !out_stall;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign up_ready = ld1;

  always_comb begin
    if (up_data.rem >= cfg.alternate_offset) begin
      within_c = {1'b0, up_data.rem} + {1'b0, cfg.group_alternates};
    end else begin
      within_c = {1'b0, up_data.rem};
    end
    if (within_c < {1'b0, cfg.alternate_offset}) begin
      limit_c = {1'b0, cfg.alternate_offset} - within_c;
    end else begin
      limit_c = {1'b0, cfg.group_size} - within_c + {1'b0, cfg.alternate_offset};
    end
    if (cfg.grouped && (up_data.cnt > {15'b0, limit_c})) begin
      run_c = {15'b0, limit_c};
    end else begin
      run_c = up_data.cnt;
    end
    qgs_c = 48'(up_data.num) * 48'(cfg.group_size);
  end

  always_comb begin
    if (grp1) begin
      phys_c = qgs1 + 48'(within1) + 48'(cfg.front_porch);
    end else begin
      phys_c = 48'(sec1) + 48'(cfg.front_porch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= up_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      within1 <= within_c;
      run1    <= run_c;
      qgs1    <= qgs_c;
      sec1    <= up_data.sec;
      grp1    <= cfg.grouped;
    end
    if (ld2) begin
      phys2 <= phys_c[46:0];
      run2  <= run1;
    end
    if (ld3) begin
      plo3 <= 38'(phys2[23:0]) * 38'(cfg.sector_bytes);
      phi3 <= 23'(phys2[46:24]) * 23'(cfg.sector_bytes);
      len3 <= 45'(run2) * 45'(cfg.sector_bytes);
      run3 <= run2;
    end
    if (ld4) begin
      byte_offset <= 47'(plo3) + {phi3, 24'b0};
      byte_length <= len3;
      run_sectors <= run3;
    end
  end

  assign out_valid = v4;

  `AGSR_ASSERT_NEXT(a_drain_empty, clk, rst, out_valid && !out_stall && !v3, !out_valid)
  `AGSR_ASSERT_NEXT(a_stage2_hold, clk, rst, v2 && !ld3, v2 && $stable(phys2))

endmodule

// ===== bench/alt_group_sector_remap_tb.sv =====
module alt_group_sector_remap_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int HOLD_CYCLES  = 300;   // long result-side hold-off
  localparam int DRAIN_CYCLES = 40;    // a little past the pipeline latency
  localparam int LIMIT_CYCLES = 500000;
  localparam int RAND_PHASES  = 10;
  localparam int RAND_ITEMS   = 80;    // per phase, about 800 in total

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  // One predicted physical run: what the block should hand back for a request.
  typedef struct packed {
    bit [46:0] offset;
    bit [44:0] length;
    bit [31:0] run;
  } phys_run_t;

  // Shadow of the settings, the run predictor and the queue of predicted runs.
  class remap_scoreboard;
    bit [15:0]   group_size;
    bit [15:0]   group_alts;
    bit [15:0]   alt_offset;
    bit [15:0]   front_porch;
    bit [13:0]   sector_bytes;
    bit [31:0]   part_base;
    phys_run_t   expected_runs[$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned mismatches;

    function new();
      group_size   = '0;
      group_alts   = '0;
      alt_offset   = '0;
      front_porch  = '0;
      sector_bytes = agsr_pkg::SectorBytesReset;
      part_base    = '0;
      accepted     = 0;
      checked      = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(agsr_pkg::agsr_reg_t idx, bit [31:0] data);
      case (idx)
        agsr_pkg::REG_GROUP_SIZE:       group_size   = data[15:0];
        agsr_pkg::REG_GROUP_ALTERNATES: group_alts   = data[15:0];
        agsr_pkg::REG_ALTERNATE_OFFSET: alt_offset   = data[15:0];
        agsr_pkg::REG_FRONT_PORCH:      front_porch  = data[15:0];
        agsr_pkg::REG_SECTOR_BYTES:     sector_bytes = data[13:0];
        agsr_pkg::REG_PARTITION_BASE:   part_base    = data;
        default: ;
      endcase
    endfunction

    // Map a partition-relative request to the next contiguous physical run.
    function phys_run_t map_run(bit [31:0] rel, bit [31:0] rem);
      bit [31:0] abs_sec;
      bit [63:0] sec, usable, grp_pos, limit, run, phys;
      phys_run_t r;
      abs_sec = rel + part_base;   // 32-bit wrap
      sec = {32'd0, abs_sec};
      if (group_alts < group_size) begin
        usable  = group_size - group_alts;
        grp_pos = sec % usable;
        // skip the alternate band
        if (grp_pos >= alt_offset) grp_pos = grp_pos + group_alts;
        // clip at the start of the next band
        if (grp_pos < alt_offset) limit = alt_offset - grp_pos;
        else limit = group_size - grp_pos + alt_offset;
        run  = (rem > limit) ? limit : {32'd0, rem};
        phys = grp_pos + (sec / usable) * group_size;
      end else begin
        run  = {32'd0, rem};
        phys = sec;
      end
      phys     = phys + front_porch;
      r.offset = 47'(phys * sector_bytes);
      r.length = 45'(run * sector_bytes);
      r.run    = run[31:0];
      return r;
    endfunction

    function void note_request(bit [31:0] rel, bit [31:0] rem);
      expected_runs.push_back(map_run(rel, rem));
      accepted++;
    endfunction

    function void check_result(bit [46:0] off, bit [44:0] len, bit [31:0] run);
      phys_run_t want;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: offset %0h length %0h run %0h",
                   $time, off, len, run);
        return;
      end
      want = expected_runs.pop_front();
      checked++;
      if (want.offset !== off || want.length !== len || want.run !== run) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result %0d differs: offset exp %0h got %0h, ",
                    "length exp %0h got %0h, run exp %0h got %0h"},
                   $time, checked, want.offset, off, want.length, len, want.run, run);
      end
    endfunction

    function int unsigned outstanding();
      return expected_runs.size();
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [31:0] rel_sector  = '0;
  logic [31:0] remaining   = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [46:0] byte_offset;
  logic [44:0] byte_length;
  logic [31:0] run_sectors;
  logic        wr_en       = 1'b0;
  logic [2:0]  wr_index    = '0;
  logic [31:0] wr_data     = '0;

  remap_scoreboard sb = new();

  stall_mode_t stall_mode    = STALL_NONE;
  logic        hold_req      = 1'b0;
  logic [15:0] stall_pattern = 16'hC3A5;
  bit          offering      = 1'b0;   // in_valid currently raised by the sender
  int unsigned setting_count = 0;

  alt_group_sector_remap uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rel_sector  (rel_sector),
    .remaining   (remaining),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_offset (byte_offset),
    .byte_length (byte_length),
    .run_sectors (run_sectors),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watch both channels at the edge; inputs change only in the NBA region,
  // so every value read here is the one the block saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(rel_sector, remaining);
      if (out_valid && !out_stall) sb.check_result(byte_offset, byte_length, run_sectors);
    end
  end

  // Result-side stall generator. A hold request freezes the output for a long
  // stretch so the pipe fills up and pushes back on the request side.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_LIGHT:   out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
          STALL_PATTERN: begin
            out_stall     <= stall_pattern[0];
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
          end
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout: %0d results still outstanding", sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Valid stays up
  // on return so back-to-back requests need no extra cycle.
  task automatic send_item(input bit [31:0] rel, input bit [31:0] rem);
    in_valid   <= 1'b1;
    rel_sector <= rel;
    remaining  <= rem;
    offering    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid (once) and idle the request side.
  task automatic idle_request(input int cycles);
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted run has come back. Step an
  // edge first so a request taken at the last edge is already noted.
  task automatic wait_drained();
    idle_request(0);
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input agsr_pkg::agsr_reg_t idx, input bit [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write all six settings; junk in the upper bits checks the width masking.
  task automatic program_settings(input bit [15:0] gs, input bit [15:0] ga,
                                  input bit [15:0] ao, input bit [15:0] fp,
                                  input bit [13:0] sbytes, input bit [31:0] pb);
    bit [31:0] junk;
    junk = $urandom;
    write_reg(agsr_pkg::REG_GROUP_SIZE,       {junk[31:16], gs});
    write_reg(agsr_pkg::REG_GROUP_ALTERNATES, {junk[15:0], ga});
    write_reg(agsr_pkg::REG_ALTERNATE_OFFSET, {junk[23:8], ao});
    write_reg(agsr_pkg::REG_FRONT_PORCH,      {junk[27:12], fp});
    write_reg(agsr_pkg::REG_SECTOR_BYTES,     {junk[17:0], sbytes});
    write_reg(agsr_pkg::REG_PARTITION_BASE,   pb);
    wr_en <= 1'b0;
    @(posedge clk);   // let the written settings and derived terms register
    setting_count++;
  endtask

  task automatic random_settings();
    int        gs, ga, ao, fp, sbytes;
    bit [31:0] pb;
    // lean toward real grouping, but keep the flat and degenerate layouts
    case ($urandom_range(0, 4))
      0:       gs = $urandom_range(1, 64);
      1:       gs = $urandom_range(65, 2000);
      2:       gs = $urandom_range(0, 65535);
      3:       gs = 0;
      default: gs = 65535;
    endcase
    case ($urandom_range(0, 5))
      0:       ga = 0;
      1, 2:    ga = (gs > 0) ? $urandom_range(0, gs - 1) : 0;
      3:       ga = $urandom_range(gs, 65535);
      default: ga = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 3))
      0:       ao = 0;
      1:       ao = $urandom_range(0, gs);
      2:       ao = (gs > ga) ? gs - ga : 0;   // band right at the usable count
      default: ao = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 2))
      0:       fp = 0;
      1:       fp = 65535;
      default: fp = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0:       sbytes = 512;
      1, 2:    sbytes = $urandom_range(1, 8192);
      3:       sbytes = 0;
      4:       sbytes = 16383;
      default: sbytes = $urandom_range(0, 16383);
    endcase
    case ($urandom_range(0, 2))
      0:       pb = '0;
      1:       pb = $urandom;
      default: pb = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
    program_settings(gs[15:0], ga[15:0], ao[15:0], fp[15:0], sbytes[13:0], pb);
  endtask

  // Random traffic under the current settings. Most requests continue a
  // transfer the way a caller would (advance by the predicted run), the rest
  // start fresh ones aimed at band edges, wrap points and field extremes.
  task automatic random_phase(input int n_items, input bit gaps, input bit with_hold);
    int        burst, k;
    bit [31:0] rel, rem, usable, chain_rel, chain_rem;
    phys_run_t step;
    burst     = $urandom_range(1, 24);
    chain_rem = '0;
    chain_rel = '0;
    usable    = (sb.group_size > sb.group_alts) ? sb.group_size - sb.group_alts : 32'd1;
    for (k = 0; k < n_items; k++) begin
      if (chain_rem != 0 && $urandom_range(0, 9) < 6) begin
        rel = chain_rel;
        rem = chain_rem;
      end else begin
        case ($urandom_range(0, 3))
          0:       rel = $urandom;
          1:       rel = $urandom_range(0, 40) * usable + sb.alt_offset
                         + $urandom_range(0, 4) - 2 - sb.part_base;
          2:       rel = 32'hFFFF_FFFF - $urandom_range(0, 300);
          default: rel = $urandom_range(0, 1000);
        endcase
        case ($urandom_range(0, 5))
          0:       rem = '0;
          1:       rem = $urandom_range(1, 64);
          2, 3:    rem = $urandom_range(1, 2 * sb.group_size + 2);
          4:       rem = $urandom;
          default: rem = 32'hFFFF_FFFF;
        endcase
      end
      step      = sb.map_run(rel, rem);
      chain_rel = rel + step.run;
      chain_rem = rem - step.run;
      send_item(rel, rem);

      if (with_hold && k == n_items / 3) begin
        // freeze the result side and keep pushing until the pipe backs up
        hold_req <= 1'b1;
        burst     = 70;
      end
      if (with_hold && k == (2 * n_items) / 3) begin
        wait_drained();   // pause until everything in flight is back
        burst = $urandom_range(1, 24);
      end

      burst--;
      if (burst <= 0) begin
        if (gaps) idle_request($urandom_range(0, 12));
        burst = $urandom_range(1, 24);
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int ph;
    stall_pattern <= 16'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, i.e. flat mapping at 512 bytes per sector.
    send_item(32'd0, 32'd0);                  // zero remaining
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // field extremes
    send_item(32'd1234, 32'd7);
    wait_drained();

    // Ordinary grouping; the last-but-one request wraps through the base.
    program_settings(16'd64, 16'd4, 16'd30, 16'd10, 14'd512, 32'd100);
    send_item(32'd0, 32'd100);
    send_item(32'd200, 32'd5);
    send_item(32'hFFFF_FF9C, 32'd50);
    send_item(32'd500, 32'd0);
    wait_drained();

    // Band starts past the usable count and past the group end.
    program_settings(16'd32, 16'd8, 16'd40, 16'd0, 14'd1, 32'd0);
    send_item(32'd0, 32'd1000);
    send_item(32'd23, 32'd1000);
    send_item(32'd24, 32'd3);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // One usable sector per group: byte offset wraps at 47 bits.
    program_settings(16'hFFFF, 16'hFFFE, 16'd0, 16'hFFFF, 14'd16383, 32'hFFFF_FFFF);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd2);
    send_item(32'h1234_5678, 32'd1);
    wait_drained();

    // Alternates equal the group size: no grouping, byte length wraps.
    program_settings(16'd5, 16'd5, 16'd3, 16'd0, 14'd16383, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000);
    wait_drained();

    // Sector size zero with alternates above the group size.
    program_settings(16'd10, 16'd200, 16'd0, 16'd7, 14'd0, 32'd55);
    send_item(32'd100, 32'd100);
    send_item(32'hFFFF_FFFF, 32'd0);
    wait_drained();

    // Single-sector groups with no alternates.
    program_settings(16'd1, 16'd0, 16'd0, 16'd1, 14'd8192, 32'd0);
    send_item(32'd0, 32'd10);
    send_item(32'hFFFF_FFFF, 32'd1);
    wait_drained();

    // Band at the very start of each group.
    program_settings(16'd100, 16'd10, 16'd0, 16'd3, 14'd4096, 32'd0);
    send_item(32'd0, 32'd200);
    send_item(32'd89, 32'd5);
    send_item(32'd90, 32'd1000);
    wait_drained();

    // Random phases, each under fresh settings and its own stall behavior.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      stall_mode <= stall_mode_t'(ph % 4);
      random_phase(RAND_ITEMS, (ph % 5) != 2, ph == 3);
    end

    stall_mode <= STALL_NONE;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests under %0d settings, %0d results compared, %0d bad.",
             sb.accepted, setting_count + 1, sb.checked, sb.mismatches);
    $display("Included a %0d-cycle output hold-off with the request side backed up.",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
